// ===== hdl/stpq_pkg.sv =====
// ----------------------------------------------------------------------------
// stpq_pkg
// Shared constants, codes and helpers for the stable priority queue.
// ----------------------------------------------------------------------------
package stpq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PRIORITY_BITS = 8;

    localparam int ID_W      = 32;
    localparam int IN_PRIO_W = 8;
    localparam int OUT_CNT_W = 5;
    localparam int ADDR_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W   = ID_W + PRIORITY_BITS;

    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CNT_W-1:0]         count_t;
    typedef logic [PRIORITY_BITS-1:0] prio_t;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_INSERTED = 2'd0;
    localparam logic [1:0] STATUS_REMOVED  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [1:0] STATUS_DROPPED  = 2'd3;

    // Circular address: base plus offset, wrapped at the queue depth.
    function automatic addr_t wrap_addr(input addr_t base, input addr_t off);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (ADDR_W+1)'(QUEUE_DEPTH)) begin
            sum = sum - (ADDR_W+1)'(QUEUE_DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    // Keep the low PRIORITY_BITS bits of the incoming priority.
    function automatic prio_t prio_in(input logic [IN_PRIO_W-1:0] p);
        logic [PRIORITY_BITS+IN_PRIO_W-1:0] ext;
        ext = {{PRIORITY_BITS{1'b0}}, p};
        return ext[PRIORITY_BITS-1:0];
    endfunction

    function automatic logic [IN_PRIO_W-1:0] prio_out(input prio_t p);
        logic [PRIORITY_BITS+IN_PRIO_W-1:0] ext;
        ext = {{IN_PRIO_W{1'b0}}, p};
        return ext[IN_PRIO_W-1:0];
    endfunction

    function automatic logic [OUT_CNT_W-1:0] count_out(input count_t c);
        logic [CNT_W+OUT_CNT_W-1:0] ext;
        ext = {{OUT_CNT_W{1'b0}}, c};
        return ext[OUT_CNT_W-1:0];
    endfunction

endpackage

// ===== hdl/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue of tickets kept in service order in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one request per item: insert (id, priority) or
//   remove the head. The m_ channel returns exactly one result item per
//   request: status, removed id and priority, and the entry count after it.
//   Smaller priority is served first; equal priorities leave in arrival order.
//   Entries sit in a circular buffer in the RAM. A remove reads the head and
//   advances the head pointer. An insert walks from the tail toward the head,
//   one entry per cycle, moving each entry of larger priority up one slot,
//   then writes the new ticket into the gap.
// Sequencing (accept to m_valid):
//   drop on full and remove on empty go straight to the result state;
//   a remove reads the head first; an insert walks over the k entries
//   of larger priority, then writes the ticket before the result state.
//   The block takes one request at a time; s_ready rises together with
//   m_valid, so the next request waits until the result is registered.
// Reset empties the queue (count and head cleared); RAM contents are left
// as they are. A stalled receiver holds the result and the block waits with
// the next result until the output register is free.
// ----------------------------------------------------------------------------
module stable_priority_queue import stpq_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [ID_W-1:0]      s_ticket_id,
    input  logic [IN_PRIO_W-1:0] s_ticket_priority,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [ID_W-1:0]      m_out_id,
    output logic [IN_PRIO_W-1:0] m_out_priority,
    output logic [OUT_CNT_W-1:0] m_entry_count
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_INS_WAIT = 3'd1;
    localparam logic [2:0] ST_INS_PUT  = 3'd2;
    localparam logic [2:0] ST_REM_WAIT = 3'd3;
    localparam logic [2:0] ST_RESP     = 3'd4;

    logic [2:0] state_reg, state_next;
    addr_t      head_reg, head_next;
    count_t     count_reg, count_next;
    addr_t      idx_reg, idx_next;

    logic [ID_W-1:0] new_id_reg, new_id_next;
    prio_t           new_prio_reg, new_prio_next;

    logic [1:0]      res_status_reg, res_status_next;
    logic [ID_W-1:0] res_id_reg, res_id_next;
    prio_t           res_prio_reg, res_prio_next;

    logic                 m_valid_reg, m_valid_next;
    logic [1:0]           m_status_reg, m_status_next;
    logic [ID_W-1:0]      m_out_id_reg, m_out_id_next;
    logic [IN_PRIO_W-1:0] m_out_priority_reg, m_out_priority_next;
    logic [OUT_CNT_W-1:0] m_entry_count_reg, m_entry_count_next;

    logic               accept;
    logic               ram_we;
    addr_t              ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    addr_t              ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    prio_t              rd_prio;
    logic [ID_W-1:0]    rd_id;

    stpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign rd_id   = ram_rdata[ENTRY_W-1:PRIORITY_BITS];
    assign rd_prio = ram_rdata[PRIORITY_BITS-1:0];

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_out_id       = m_out_id_reg;
    assign m_out_priority = m_out_priority_reg;
    assign m_entry_count  = m_entry_count_reg;

    always_comb begin
        state_next          = state_reg;
        head_next           = head_reg;
        count_next          = count_reg;
        idx_next            = idx_reg;
        new_id_next         = new_id_reg;
        new_prio_next       = new_prio_reg;
        res_status_next     = res_status_reg;
        res_id_next         = res_id_reg;
        res_prio_next       = res_prio_reg;
        m_valid_next        = m_valid_reg;
        m_status_next       = m_status_reg;
        m_out_id_next       = m_out_id_reg;
        m_out_priority_next = m_out_priority_reg;
        m_entry_count_next  = m_entry_count_reg;
        ram_we              = 1'b0;
        ram_waddr           = head_reg;
        ram_wdata           = {new_id_reg, new_prio_reg};
        ram_re              = 1'b0;
        ram_raddr           = head_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    new_id_next   = s_ticket_id;
                    new_prio_next = prio_in(s_ticket_priority);
                    res_id_next   = '0;
                    res_prio_next = '0;
                    if (s_req_type == REQ_INSERT) begin
                        if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                            res_status_next = STATUS_DROPPED;
                            state_next      = ST_RESP;
                        end else if (count_reg == '0) begin
                            state_next = ST_INS_PUT;
                        end else begin
                            // start the walk at the tail
                            idx_next   = ADDR_W'(count_reg - CNT_W'(1));
                            ram_re     = 1'b1;
                            ram_raddr  = wrap_addr(head_reg, ADDR_W'(count_reg - CNT_W'(1)));
                            state_next = ST_INS_WAIT;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_status_next = STATUS_EMPTY;
                            state_next      = ST_RESP;
                        end else begin
                            ram_re     = 1'b1;
                            ram_raddr  = head_reg;
                            state_next = ST_REM_WAIT;
                        end
                    end
                end
            end
            ST_INS_WAIT: begin
                ram_we    = 1'b1;
                ram_waddr = wrap_addr(head_reg, idx_reg + ADDR_W'(1));
                if (rd_prio > new_prio_reg) begin
                    // move this entry up one slot and keep walking
                    ram_wdata = ram_rdata;
                    if (idx_reg == '0) begin
                        state_next = ST_INS_PUT;
                    end else begin
                        idx_next   = idx_reg - ADDR_W'(1);
                        ram_re     = 1'b1;
                        ram_raddr  = wrap_addr(head_reg, idx_reg - ADDR_W'(1));
                    end
                end else begin
                    ram_wdata       = {new_id_reg, new_prio_reg};
                    count_next      = count_reg + CNT_W'(1);
                    res_status_next = STATUS_INSERTED;
                    state_next      = ST_RESP;
                end
            end
            ST_INS_PUT: begin
                ram_we          = 1'b1;
                ram_waddr       = head_reg;
                ram_wdata       = {new_id_reg, new_prio_reg};
                count_next      = count_reg + CNT_W'(1);
                res_status_next = STATUS_INSERTED;
                state_next      = ST_RESP;
            end
            ST_REM_WAIT: begin
                res_id_next     = rd_id;
                res_prio_next   = rd_prio;
                head_next       = wrap_addr(head_reg, ADDR_W'(1));
                count_next      = count_reg - CNT_W'(1);
                res_status_next = STATUS_REMOVED;
                state_next      = ST_RESP;
            end
            ST_RESP: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_status_next       = res_status_reg;
                    m_out_id_next       = res_id_reg;
                    m_out_priority_next = prio_out(res_prio_reg);
                    m_entry_count_next  = count_out(count_reg);
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg            <= idx_next;
        new_id_reg         <= new_id_next;
        new_prio_reg       <= new_prio_next;
        res_status_reg     <= res_status_next;
        res_id_reg         <= res_id_next;
        res_prio_reg       <= res_prio_next;
        m_status_reg       <= m_status_next;
        m_out_id_reg       <= m_out_id_next;
        m_out_priority_reg <= m_out_priority_next;
        m_entry_count_reg  <= m_entry_count_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !ram_we)
        else $error("RAM written while idle");

    a_idle_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE && !s_valid |=> $stable(count_reg) && $stable(head_reg))
        else $error("queue state moved without a request");

    a_result_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_REMOVED |-> m_out_id == '0 && m_out_priority == '0)
        else $error("nonzero ticket fields on a result without removal");

    a_remove_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_REM_WAIT |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("remove did not lower the entry count");

endmodule

// ===== hdl/stpq_ram.sv =====
// ----------------------------------------------------------------------------
// stpq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
